FILE: rtl/vrfe_pkg.sv
// vrfe_pkg: shared types and constants of the vicinity reader frame encoder
// no dependencies; imported by every module of the block
package vrfe_pkg;

    // payload of one input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // payload of one result request
    typedef struct packed {
        logic [7:0] symbol_bits;
        logic [3:0] symbol_length;
        logic       end_of_run;
        logic       end_of_frame;
    } t_out;

    // classified byte handed from the front to the back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic        crc_en;
        logic [15:0] crc_val;
    } t_job;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    localparam logic [7:0] SYM_IDLE  = 8'hFF;
    localparam logic [7:0] SYM_SOF   = 8'h7B;
    localparam logic [7:0] SYM_EOF   = 8'h0D;
    localparam logic [7:0] SYM_PAIR0 = 8'hBF;
    localparam logic [7:0] SYM_PAIR1 = 8'hEF;
    localparam logic [7:0] SYM_PAIR2 = 8'hFB;
    localparam logic [7:0] SYM_PAIR3 = 8'hFE;

    localparam logic [3:0] LEN_FULL = 4'd8;
    localparam logic [3:0] LEN_EOF  = 4'd4;

endpackage

FILE: rtl/vrfe_front.sv
// vrfe_front: accepts command bytes, tracks frame state and running crc-16
// depends on vrfe_pkg
module vrfe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vrfe_pkg::t_in    i_in_data,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_q_full,
    output logic             o_push,
    output vrfe_pkg::t_job   o_job
);
    import vrfe_pkg::*;

    logic        r_append_crc;
    logic        r_frame_open;
    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // reflected crc-16 over one byte, lsb first
    function automatic logic [15:0] f_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;
    assign n_crc      = f_crc_byte(r_crc, i_in_data.data_byte);

    always_comb begin
        o_job.data_byte = i_in_data.data_byte;
        o_job.first     = !r_frame_open;
        o_job.last      = i_in_data.last_byte;
        o_job.crc_en    = i_in_data.last_byte && r_append_crc;
        o_job.crc_val   = ~n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_append_crc <= 1'b1;
            r_frame_open <= 1'b0;
            r_crc        <= CRC_PRESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_append_crc <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_frame_open <= !i_in_data.last_byte;
                r_crc        <= i_in_data.last_byte ? CRC_PRESET : n_crc;
            end
        end
    end

endmodule

FILE: rtl/vrfe_queue.sv
// vrfe_queue: short show-ahead queue of classified bytes
// depends on vrfe_pkg
module vrfe_queue #(
    parameter int DEPTH = vrfe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vrfe_pkg::t_job   i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output vrfe_pkg::t_job   o_head
);
    import vrfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/vrfe_back.sv
// vrfe_back: symbol sequencer, one line symbol per cycle while the output is ready, into an output register
// depends on vrfe_pkg
module vrfe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  vrfe_pkg::t_job   i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vrfe_pkg::t_out   o_out_data
);
    import vrfe_pkg::*;

    // step map: idle x3, start, 4 data, 8 crc, end pattern, idle x3
    localparam logic [4:0] STEP_FIRST     = 5'd0;
    localparam logic [4:0] STEP_SOF       = 5'd3;
    localparam logic [4:0] STEP_DATA      = 5'd4;
    localparam logic [4:0] STEP_DATA_LAST = 5'd7;
    localparam logic [4:0] STEP_CRC       = 5'd8;
    localparam logic [4:0] STEP_CRC_LAST  = 5'd15;
    localparam logic [4:0] STEP_EOF       = 5'd16;
    localparam logic [4:0] STEP_DONE      = 5'd19;

    logic       r_started;
    logic [4:0] r_step;
    logic       r_out_valid;
    t_out       r_out;

    logic [4:0] w_step;
    logic [4:0] w_next;
    logic       w_done;
    logic       w_adv;
    logic [7:0] w_byte;
    t_out       w_sym;

    function automatic logic [7:0] f_pair(input logic [1:0] p);
        logic [7:0] s;
        unique case (p)
            2'd0:    s = SYM_PAIR0;
            2'd1:    s = SYM_PAIR1;
            2'd2:    s = SYM_PAIR2;
            default: s = SYM_PAIR3;
        endcase
        return s;
    endfunction

    assign w_step = r_started ? r_step : (i_head.first ? STEP_FIRST : STEP_DATA);
    assign w_adv  = !i_q_empty && (!r_out_valid || i_out_ready);
    assign o_pop  = w_adv && w_done;

    // source byte of a data or crc symbol
    always_comb begin
        if (w_step <= STEP_DATA_LAST) begin
            w_byte = i_head.data_byte;
        end else if (w_step[2]) begin
            w_byte = i_head.crc_val[15:8];
        end else begin
            w_byte = i_head.crc_val[7:0];
        end
    end

    always_comb begin
        w_sym.symbol_length = LEN_FULL;
        w_sym.end_of_run    = w_done;
        w_sym.end_of_frame  = (w_step == STEP_DONE);
        priority if (w_step < STEP_SOF) begin
            w_sym.symbol_bits = SYM_IDLE;
        end else if (w_step == STEP_SOF) begin
            w_sym.symbol_bits = SYM_SOF;
        end else if (w_step <= STEP_CRC_LAST) begin
            w_sym.symbol_bits = f_pair(w_byte[{w_step[1:0], 1'b0} +: 2]);
        end else if (w_step == STEP_EOF) begin
            w_sym.symbol_bits   = SYM_EOF;
            w_sym.symbol_length = LEN_EOF;
        end else begin
            w_sym.symbol_bits = SYM_IDLE;
        end
    end

    always_comb begin
        w_done = 1'b0;
        w_next = w_step + 5'd1;
        if (w_step == STEP_DATA_LAST) begin
            if (!i_head.last) begin
                w_done = 1'b1;
            end else if (i_head.crc_en) begin
                w_next = STEP_CRC;
            end else begin
                w_next = STEP_EOF;
            end
        end else if (w_step == STEP_DONE) begin
            w_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_step      <= STEP_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_started   <= !w_done;
                r_step      <= w_next;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_sym;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/vicinity_reader_frame_encoder.sv
// vicinity_reader_frame_encoder: top level of the reader frame encoder
// depends on vrfe_pkg, vrfe_front, vrfe_queue, vrfe_back

// Turns command bytes into one-of-four line symbols. One byte is taken per
// request; the byte that opens a frame is preceded by three idle chunks and
// the start pattern, every byte gives four 8-bit symbols (lowest bit pair
// first), and a byte flagged last is followed by the complemented crc-16 (when
// append_crc is 1), the 4-bit end pattern and three idle chunks. Results leave
// at one symbol per cycle from the back sequencer while the output is ready,
// so a middle byte gives 4 symbols, an opening byte 8, a closing byte 8 or 16
// (without or with the crc) and a byte that both opens and closes a frame 12 or
// 20; the symbol rate of the back sequencer is what sets the throughput. The
// front takes a byte whenever the queue has room, so bytes can arrive back to
// back while earlier ones are still being sent. append_crc resets to 1 and is
// sampled when the last byte of a frame is taken.
module vicinity_reader_frame_encoder #(
    parameter int QUEUE_DEPTH = vrfe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vrfe_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vrfe_pkg::t_out   o_out_data,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data
);
    import vrfe_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_empty;
    t_job w_job;
    t_job w_head;

    // front: request acceptance, frame tracking, crc
    vrfe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_job         (w_job)
    );

    // decouples byte intake from symbol output
    vrfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    // back: walks each byte's symbol sequence, one symbol per cycle while the output is ready
    vrfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // no write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("queue written while full");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("queue read while empty");

    // frame close always ends the byte's run
    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_frame |-> o_out_data.end_of_run)
        else $error("end of frame without end of run");

    // short symbols are only the end pattern
    a_short_is_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.symbol_length != LEN_FULL)
            |-> (o_out_data.symbol_length == LEN_EOF) && (o_out_data.symbol_bits == SYM_EOF))
        else $error("bad short symbol");
`endif

endmodule
